// File: rtl/cag_pkg.sv
// cag_pkg: shared types and constants for the cave automaton generator.
// No dependencies; every other file in rtl/ except cag_ram imports it.
package cag_pkg;

	localparam int SIDE_W     = 7;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [SIDE_W-1:0] MIN_SIDE = 7'd4;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GRID_DEPTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DEATH_LIMIT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BIRTH_LIMIT = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_WALLS  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WALL_CHANCE = 3'd6;

	// reset values of the registers
	localparam logic [6:0]  RST_GRID_WIDTH  = 7'd64;
	localparam logic [6:0]  RST_GRID_DEPTH  = 7'd64;
	localparam logic [7:0]  RST_PASS_COUNT  = 8'd4;
	localparam logic [3:0]  RST_DEATH_LIMIT = 4'd4;
	localparam logic [3:0]  RST_BIRTH_LIMIT = 4'd4;
	localparam logic        RST_EDGE_WALLS  = 1'b1;
	localparam logic [15:0] RST_WALL_CHANCE = 16'd29491;

	// neighborhood scan: nine slots in raster order, center in the middle
	localparam logic [3:0] SLOT_CENTER = 4'd4;
	localparam logic [3:0] SLOT_LAST   = 4'd8;

	localparam logic [7:0] PASS_SAT = 8'hFF;

	typedef enum logic [1:0] {
		PH_FILL   = 2'd0,
		PH_SMOOTH = 2'd1,
		PH_DONE   = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		OFF_NEG  = 2'd0,
		OFF_ZERO = 2'd1,
		OFF_POS  = 2'd2
	} off_t;

	typedef struct packed {
		logic [6:0]  grid_width;
		logic [6:0]  grid_depth;
		logic [7:0]  pass_count;
		logic [3:0]  death_limit;
		logic [3:0]  birth_limit;
		logic        edge_walls;
		logic [15:0] wall_chance;
	} cfg_t;

	typedef struct packed {
		logic [15:0] random_sample;
		logic        restart;
	} in_item_t;

	typedef struct packed {
		logic [5:0] cell_x;
		logic [5:0] cell_y;
		logic       is_wall;
		logic       wrote;
		logic [1:0] phase_now;
		logic [7:0] pass_index;
		logic       finished;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic       load;
		logic       div_init;
		logic       div_step;
		logic       rd_en;
		logic [3:0] rd_slot;
		logic       finish;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic active;
		logic in_range;
		logic smooth;
		logic out_free;
	} status_t;

	function automatic off_t slot_dx(input logic [3:0] slot);
		off_t r;
		case (slot) inside
			4'd0, 4'd3, 4'd6: r = OFF_NEG;
			4'd2, 4'd5, 4'd8: r = OFF_POS;
			default:          r = OFF_ZERO;
		endcase
		return r;
	endfunction

	function automatic off_t slot_dy(input logic [3:0] slot);
		off_t r;
		case (slot) inside
			[4'd0:4'd2]: r = OFF_NEG;
			[4'd6:4'd8]: r = OFF_POS;
			default:     r = OFF_ZERO;
		endcase
		return r;
	endfunction

endpackage

// File: rtl/cag_in_if.sv
// cag_in_if: valid/ready channel carrying one input item.
// Depends on cag_pkg for the payload type.
interface cag_in_if import cag_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/cag_out_if.sv
// cag_out_if: valid/ready channel carrying one result item.
// Depends on cag_pkg for the payload type.
interface cag_out_if import cag_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/cag_ram.sv
// cag_ram: generic single-port RAM, registered read, no reset.
// No dependencies.
module cag_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/cag_ctrl.sv
// cag_ctrl: sequencer for one item: check, row divide, neighbor scan, finish.
// Depends on cag_pkg (cmd_t, status_t, slot constants).
module cag_ctrl import cag_pkg::*; #(
	parameter int DIV_STEPS = 6
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  status_t st,
	output cmd_t    cmd
);

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_CHECK  = 6'b000010,
		S_DIV    = 6'b000100,
		S_READ   = 6'b001000,
		S_DRAIN  = 6'b010000,
		S_FINISH = 6'b100000
	} state_t;

	localparam logic [3:0] DIV_LAST = 4'(DIV_STEPS - 1);

	state_t     state_q, state_d;
	logic [3:0] cnt_q, cnt_d;

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_CHECK;
				end
			end
			S_CHECK: begin
				if (st.active && st.in_range) begin
					cmd.div_init = 1'b1;
					cnt_d        = '0;
					state_d      = S_DIV;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 4'd1;
				if (cnt_q == DIV_LAST) begin
					cnt_d   = '0;
					state_d = st.smooth ? S_READ : S_FINISH;
				end
			end
			S_READ: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_slot = cnt_q;
				cnt_d       = cnt_q + 4'd1;
				if (cnt_q == SLOT_LAST) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

endmodule

// File: rtl/cag_dpath.sv
// cag_dpath: generation state, row divider, neighbor counter, both planes, result register.
// Depends on cag_pkg and cag_ram.
module cag_dpath import cag_pkg::*; #(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_DEPTH = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  cmd_t      cmd,
	output status_t   st,
	input  in_item_t  in_item,
	input  logic      out_ready,
	output logic      out_valid,
	output out_item_t out_item
);

	// sides are 7-bit registers, so the usable grid stops at 127
	localparam int WMAX = (MAX_WIDTH > 127) ? 127 : MAX_WIDTH;
	localparam int DMAX = (MAX_DEPTH > 127) ? 127 : MAX_DEPTH;
	localparam int XW   = $clog2(WMAX);
	localparam int YW   = $clog2(DMAX);
	localparam int CW   = $clog2(WMAX * DMAX + 1);
	localparam int AW   = XW + YW;

	localparam logic [SIDE_W-1:0] WMAX_V = SIDE_W'(WMAX);
	localparam logic [SIDE_W-1:0] DMAX_V = SIDE_W'(DMAX);

	// live grid size
	logic [SIDE_W-1:0]   w, d;
	logic [2*SIDE_W-1:0] area;

	always_comb begin
		if (cfg.grid_width < MIN_SIDE)    w = MIN_SIDE;
		else if (cfg.grid_width > WMAX_V) w = WMAX_V;
		else                              w = cfg.grid_width;
		if (cfg.grid_depth < MIN_SIDE)    d = MIN_SIDE;
		else if (cfg.grid_depth > DMAX_V) d = DMAX_V;
		else                              d = cfg.grid_depth;
		area = (2*SIDE_W)'(w) * (2*SIDE_W)'(d);
	end

	// generation state
	logic [CW-1:0] cursor_q, total_q;
	logic [7:0]    passes_q;
	phase_t        phase_q;
	logic          sel_q;
	logic [15:0]   sample_q;

	// row divider: remainder ends as x, quotient as y
	logic [CW-1:0] rem_q, dvs_q;
	logic [YW-1:0] yq_q;

	// neighborhood accumulation
	logic [3:0] nbr_q;
	logic       ctr_q;
	logic       rd_vld_s1, oob_s1;
	logic [3:0] slot_s1;

	out_item_t out_q;
	logic      out_valid_q;

	logic [XW-1:0] x;
	logic [YW-1:0] y;
	logic          xl, xh, yl, yh;

	assign x  = rem_q[XW-1:0];
	assign y  = yq_q;
	assign xl = (x == '0);
	assign yl = (y == '0);
	assign xh = (SIDE_W'(x) + SIDE_W'(1) == w);
	assign yh = (SIDE_W'(y) + SIDE_W'(1) == d);

	assign st.active   = (phase_q != PH_DONE);
	assign st.in_range = (cursor_q < total_q);
	assign st.smooth   = (phase_q == PH_SMOOTH);
	assign st.out_free = !out_valid_q || out_ready;

	// neighbor address for the slot being issued
	off_t          dx, dy;
	logic          oob;
	logic [XW-1:0] nx;
	logic [YW-1:0] ny;
	logic [AW-1:0] rd_addr;

	always_comb begin
		dx  = slot_dx(cmd.rd_slot);
		dy  = slot_dy(cmd.rd_slot);
		oob = (dx == OFF_NEG && xl) || (dx == OFF_POS && xh) ||
		      (dy == OFF_NEG && yl) || (dy == OFF_POS && yh);
		case (dx)
			OFF_NEG: nx = x - XW'(1);
			OFF_POS: nx = x + XW'(1);
			default: nx = x;
		endcase
		case (dy)
			OFF_NEG: ny = y - YW'(1);
			OFF_POS: ny = y + YW'(1);
			default: ny = y;
		endcase
		rd_addr = {ny, nx};
	end

	// planes
	logic          rdata_a, rdata_b, rd_bit;
	logic          wr_en, wr_b, we_a, we_b, wall;
	logic [AW-1:0] wr_addr;

	assign wr_en   = cmd.finish && st.active && st.in_range;
	assign wr_b    = (phase_q == PH_FILL) ? sel_q : !sel_q;
	assign we_a    = wr_en && !wr_b;
	assign we_b    = wr_en && wr_b;
	assign wr_addr = {y, x};
	assign rd_bit  = sel_q ? rdata_b : rdata_a;

	cag_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_plane_a (
		.clk   (clk),
		.en    (we_a || cmd.rd_en),
		.we    (we_a),
		.addr  (we_a ? wr_addr : rd_addr),
		.wdata (wall),
		.rdata (rdata_a)
	);

	cag_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_plane_b (
		.clk   (clk),
		.en    (we_b || cmd.rd_en),
		.we    (we_b),
		.addr  (we_b ? wr_addr : rd_addr),
		.wdata (wall),
		.rdata (rdata_b)
	);

	// new cell value and next generation state
	logic          border;
	logic [CW-1:0] cur_inc;
	logic          wrap;
	logic [7:0]    passes_inc;
	phase_t        phase_d;
	logic [7:0]    passes_d;
	logic          sel_d;
	logic [CW-1:0] cursor_d;
	logic [XW+5:0] x_ext;
	logic [YW+5:0] y_ext;

	always_comb begin
		border = cfg.edge_walls && (xl || yl || xh || yh);
		if (phase_q == PH_FILL) begin
			wall = border || (sample_q < cfg.wall_chance);
		end else if (border) begin
			wall = 1'b1;
		end else if (ctr_q) begin
			wall = !(nbr_q < cfg.death_limit);
		end else begin
			wall = (nbr_q > cfg.birth_limit);
		end

		cur_inc    = st.in_range ? cursor_q + CW'(1) : cursor_q;
		wrap       = (cur_inc >= total_q);
		passes_inc = (passes_q == PASS_SAT) ? passes_q : passes_q + 8'd1;

		phase_d  = phase_q;
		passes_d = passes_q;
		sel_d    = sel_q;
		cursor_d = cursor_q;
		if (st.active) begin
			cursor_d = cur_inc;
			if (wrap) begin
				cursor_d = '0;
				if (phase_q == PH_FILL) begin
					phase_d = (cfg.pass_count == 8'd0) ? PH_DONE : PH_SMOOTH;
				end else begin
					sel_d    = !sel_q;
					passes_d = passes_inc;
					if (passes_inc >= cfg.pass_count) phase_d = PH_DONE;
				end
			end
		end

		x_ext = {6'd0, x};
		y_ext = {6'd0, y};
	end

	// item registers and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			passes_q    <= '0;
			phase_q     <= PH_FILL;
			sel_q       <= 1'b0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
			if (cmd.load && in_item.restart) begin
				cursor_q <= '0;
				passes_q <= '0;
				phase_q  <= PH_FILL;
				sel_q    <= 1'b0;
			end else if (cmd.finish) begin
				cursor_q <= cursor_d;
				passes_q <= passes_d;
				phase_q  <= phase_d;
				sel_q    <= sel_d;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			sample_q <= in_item.random_sample;
			total_q  <= CW'(area);
		end
		if (cmd.div_init) begin
			rem_q <= cursor_q;
			dvs_q <= CW'(w) << (YW - 1);
			yq_q  <= '0;
			nbr_q <= '0;
			ctr_q <= 1'b0;
		end else if (cmd.div_step) begin
			if (rem_q >= dvs_q) begin
				rem_q <= rem_q - dvs_q;
				yq_q  <= {yq_q[YW-2:0], 1'b1};
			end else begin
				yq_q <= {yq_q[YW-2:0], 1'b0};
			end
			dvs_q <= dvs_q >> 1;
		end
		slot_s1 <= cmd.rd_slot;
		oob_s1  <= oob;
		if (rd_vld_s1) begin
			if (slot_s1 == SLOT_CENTER) begin
				ctr_q <= rd_bit;
			end else begin
				nbr_q <= nbr_q + 4'(oob_s1 | rd_bit);
			end
		end
		if (cmd.finish) begin
			out_q.cell_x     <= wr_en ? x_ext[5:0] : 6'd0;
			out_q.cell_y     <= wr_en ? y_ext[5:0] : 6'd0;
			out_q.is_wall    <= wr_en && wall;
			out_q.wrote      <= wr_en;
			out_q.phase_now  <= phase_d;
			out_q.pass_index <= passes_d;
			out_q.finished   <= (phase_d == PH_DONE);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// File: rtl/cave_automaton_generator.sv
// cave_automaton_generator: one grid cell per item, fill then 4-5 rule smoothing passes.
// Each item is checked first; done items and cells past the grid go straight to finish.
// Other items run the row divider (one quotient bit a cycle), and in smoothing also the
// nine neighbor reads from the single plane port (one a cycle, plus a drain). Finish waits
// for room in the result register; the next item can be accepted in the cycle after the
// result is registered. Reset clears control state and loads the configuration defaults.
module cave_automaton_generator import cag_pkg::*; #(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_DEPTH = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	cag_in_if.sink                in_ch,
	cag_out_if.source             out_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	// row count bounds the divider's quotient width
	localparam int DMAX = (MAX_DEPTH > 127) ? 127 : MAX_DEPTH;
	localparam int YW   = $clog2(DMAX);

	cfg_t    cfg_q;
	cmd_t    cmd;
	status_t st;

	// Configuration registers. Read live by the datapath on every item; the user must make
	// writes only while the block is idle (the block does not enforce it), so no shadowing is needed.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_width  <= RST_GRID_WIDTH;
			cfg_q.grid_depth  <= RST_GRID_DEPTH;
			cfg_q.pass_count  <= RST_PASS_COUNT;
			cfg_q.death_limit <= RST_DEATH_LIMIT;
			cfg_q.birth_limit <= RST_BIRTH_LIMIT;
			cfg_q.edge_walls  <= RST_EDGE_WALLS;
			cfg_q.wall_chance <= RST_WALL_CHANCE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GRID_WIDTH:  cfg_q.grid_width  <= cfg_data[6:0];
				REG_GRID_DEPTH:  cfg_q.grid_depth  <= cfg_data[6:0];
				REG_PASS_COUNT:  cfg_q.pass_count  <= cfg_data[7:0];
				REG_DEATH_LIMIT: cfg_q.death_limit <= cfg_data[3:0];
				REG_BIRTH_LIMIT: cfg_q.birth_limit <= cfg_data[3:0];
				REG_EDGE_WALLS:  cfg_q.edge_walls  <= cfg_data[0];
				REG_WALL_CHANCE: cfg_q.wall_chance <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Controller: accepts an item only when idle, then walks check -> divide ->
	// (smoothing: nine neighbor reads + drain) -> finish; done items and cells past the grid
	// go from check straight to finish. Finish waits for room in the result register, so a result
	// still waiting downstream holds the item in finish and blocks the next item's acceptance.
	cag_ctrl #(.DIV_STEPS(YW)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.st       (st),
		.cmd      (cmd)
	);

	// Datapath: cursor/pass/phase state, cursor-to-(x,y) divider,
	// neighbor counter, the two 1-bit planes and the result register.
	cag_dpath #(.MAX_WIDTH(MAX_WIDTH), .MAX_DEPTH(MAX_DEPTH)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd       (cmd),
		.st        (st),
		.in_item   (in_ch.data),
		.out_ready (out_ch.ready),
		.out_valid (out_ch.valid),
		.out_item  (out_ch.data)
	);

	// an accepted item keeps the block busy for at least the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input accepted while previous item in flight");

	// finished flag agrees with the reported phase
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.data.finished == (out_ch.data.phase_now == PH_DONE)))
		else $error("finished flag disagrees with phase");

	// an item that wrote nothing reports a zero cell
	assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.data.wrote |->
			out_ch.data.cell_x == 6'd0 && out_ch.data.cell_y == 6'd0 && !out_ch.data.is_wall)
		else $error("cell fields set on an item without a write");

endmodule

// File: bench/tb_cave_automaton_generator.sv
// tb_cave_automaton_generator: self-checking bench for the cave automaton generator.
// Depends on cag_pkg, cag_in_if, cag_out_if and rtl/cave_automaton_generator.sv.
module tb_cave_automaton_generator;
	import cag_pkg::*;

	localparam int MAP_W          = 64;
	localparam int MAP_D          = 64;
	localparam int WATCHDOG_LIMIT = 1000;  // slowest item is a smoothing item held by back-pressure stalls
	localparam int SETTLE_CYCLES  = 40;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	cag_in_if  cell_in ();
	cag_out_if cell_out ();

	cave_automaton_generator #(
		.MAX_WIDTH (MAP_W),
		.MAX_DEPTH (MAP_D)
	) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (cell_in),
		.out_ch    (cell_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------
	// Bench copy of the generator: register file, both map planes and
	// the scan state. The maps advance once per accepted item, the register file on each write.
	// ---------------------------------------------------------------
	cfg_t       map_cfg;
	logic       map_a [MAP_W*MAP_D];
	logic       map_b [MAP_W*MAP_D];
	logic       map_sel;      // 0: map_a holds the current generation
	int         scan_pos;     // raster position of the next cell
	logic [7:0] passes_seen;
	phase_t     gen_phase;

	out_item_t  cells_due [$];  // expected results, oldest first

	bit bursts_on;              // random idling on both channels
	int stall_left = 0;
	int quiet_cycles = 0;

	int cells_sent      = 0;
	int results_checked = 0;
	int maps_done       = 0;
	int reg_writes      = 0;
	int mismatch_count  = 0;

	function automatic int usable_side(input logic [6:0] reg_val, input int hi);
		if (reg_val < MIN_SIDE)
			return int'(MIN_SIDE);
		if (reg_val > hi)
			return hi;
		return int'(reg_val);
	endfunction

	// Advance the bench map by one item and return the result it should produce.
	function automatic out_item_t advance_map(input in_item_t it);
		out_item_t r;
		int        w, d, total, x, y, idx, n, nx, ny;
		logic      wall, border, here;
		w     = usable_side(map_cfg.grid_width, MAP_W);
		d     = usable_side(map_cfg.grid_depth, MAP_D);
		total = w * d;
		r     = '0;
		if (it.restart) begin
			map_sel     = 1'b0;
			scan_pos    = 0;
			passes_seen = '0;
			gen_phase   = PH_FILL;
		end
		if (gen_phase != PH_DONE) begin
			// a shrunken grid can leave the cursor past the end: nothing written then
			if (scan_pos < total) begin
				x      = scan_pos % w;
				y      = scan_pos / w;
				idx    = y * MAP_W + x;
				border = map_cfg.edge_walls && (x == 0 || y == 0 || x == w - 1 || y == d - 1);
				if (gen_phase == PH_FILL) begin
					wall = border || (it.random_sample < map_cfg.wall_chance);
					if (map_sel)
						map_b[idx] = wall;
					else
						map_a[idx] = wall;
				end else begin
					// off-grid neighbors count as walls
					n = 0;
					for (int oy = -1; oy <= 1; oy++) begin
						for (int ox = -1; ox <= 1; ox++) begin
							nx = x + ox;
							ny = y + oy;
							if (ox != 0 || oy != 0) begin
								if (nx < 0 || ny < 0 || nx >= w || ny >= d)
									n++;
								else if (map_sel ? map_b[ny*MAP_W + nx] : map_a[ny*MAP_W + nx])
									n++;
							end
						end
					end
					here = map_sel ? map_b[idx] : map_a[idx];
					if (border)
						wall = 1'b1;
					else if (here)
						wall = !(n < map_cfg.death_limit);
					else
						wall = (n > map_cfg.birth_limit);
					if (map_sel)
						map_a[idx] = wall;
					else
						map_b[idx] = wall;
				end
				r.cell_x  = 6'(x);
				r.cell_y  = 6'(y);
				r.is_wall = wall;
				r.wrote   = 1'b1;
				scan_pos++;
			end
			if (scan_pos >= total) begin
				scan_pos = 0;
				if (gen_phase == PH_FILL) begin
					gen_phase = (map_cfg.pass_count == 8'd0) ? PH_DONE : PH_SMOOTH;
				end else begin
					map_sel = ~map_sel;
					if (passes_seen != PASS_SAT)
						passes_seen++;
					if (passes_seen >= map_cfg.pass_count)
						gen_phase = PH_DONE;
				end
				if (gen_phase == PH_DONE)
					maps_done++;
			end
		end
		r.phase_now  = gen_phase;
		r.pass_index = passes_seen;
		r.finished   = (gen_phase == PH_DONE);
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------
	function automatic logic [15:0] pick_sample();
		case ($urandom_range(0, 9))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Sizes stay within 6x6: both planes are fully written there by the first test,
	// so no pass can read a cell that was never filled.
	function automatic logic [CFG_DATA_W-1:0] random_reg_value(input logic [CFG_IDX_W-1:0] sel);
		case (sel)
			REG_GRID_WIDTH, REG_GRID_DEPTH:   return CFG_DATA_W'($urandom_range(0, 6));
			REG_PASS_COUNT:                   return CFG_DATA_W'($urandom_range(0, 3));
			REG_DEATH_LIMIT, REG_BIRTH_LIMIT: return CFG_DATA_W'($urandom_range(0, 9));
			REG_EDGE_WALLS:                   return CFG_DATA_W'($urandom_range(0, 1));
			default:                          return 16'($urandom);
		endcase
	endfunction

	// One item; the expectation is queued at the accepting edge.
	task automatic send_cell(input logic [15:0] sample, input logic fresh);
		int       gap;
		in_item_t item;
		gap                = 0;
		item.random_sample = sample;
		item.restart       = fresh;
		if (bursts_on && $urandom_range(0, 99) < 30)
			gap = $urandom_range(1, 4);
		if (gap > 0) begin
			cell_in.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cell_in.valid <= 1'b1;
		cell_in.data  <= item;
		@(posedge clk);
		while (cell_in.ready !== 1'b1) @(posedge clk);
		cells_due.push_back(advance_map(item));
		cells_sent++;
	endtask

	task automatic run_cells(input int count);
		repeat (count) send_cell(pick_sample(), 1'b0);
	endtask

	// Drop valid in the step of the last accept, then wait out every result.
	task automatic drain_cells();
		cell_in.valid <= 1'b0;
		while (cells_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (sel)
			REG_GRID_WIDTH:  map_cfg.grid_width  = val[6:0];
			REG_GRID_DEPTH:  map_cfg.grid_depth  = val[6:0];
			REG_PASS_COUNT:  map_cfg.pass_count  = val[7:0];
			REG_DEATH_LIMIT: map_cfg.death_limit = val[3:0];
			REG_BIRTH_LIMIT: map_cfg.birth_limit = val[3:0];
			REG_EDGE_WALLS:  map_cfg.edge_walls  = val[0];
			REG_WALL_CHANCE: map_cfg.wall_chance = val[15:0];
			default: ;
		endcase
		reg_writes++;
		@(posedge clk);
	endtask

	task automatic setup_map(input int w, input int d, input int passes, input int death,
			input int birth, input bit edges, input logic [15:0] chance);
		write_reg(REG_GRID_WIDTH, CFG_DATA_W'(w));
		write_reg(REG_GRID_DEPTH, CFG_DATA_W'(d));
		write_reg(REG_PASS_COUNT, CFG_DATA_W'(passes));
		write_reg(REG_DEATH_LIMIT, CFG_DATA_W'(death));
		write_reg(REG_BIRTH_LIMIT, CFG_DATA_W'(birth));
		write_reg(REG_EDGE_WALLS, CFG_DATA_W'(edges));
		write_reg(REG_WALL_CHANCE, chance);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Full 6x6 fill plus one pass: afterwards both planes hold every cell of 6x6.
	task automatic test_prime_map();
		setup_map(6, 6, 1, 4, 4, 0, 16'h8000);
		send_cell(pick_sample(), 1'b1);
		run_cells(73);
		drain_cells();
	endtask

	// Sample and chance extremes, zero passes, items after completion.
	task automatic test_fill_extremes();
		setup_map(4, 4, 0, 4, 4, 0, 16'hFFFF);
		send_cell(16'hFFFF, 1'b1);  // equal to chance: floor
		send_cell(16'hFFFE, 1'b0);
		send_cell(16'h0000, 1'b0);
		run_cells(13);
		run_cells(2);               // done: nothing written
		drain_cells();
		write_reg(REG_WALL_CHANCE, 16'h0000);
		send_cell(16'h0000, 1'b1);  // nothing is below zero
		send_cell(16'hFFFF, 1'b0);
		run_cells(2);
		drain_cells();
	endtask

	// Limits at both ends, including values above eight.
	task automatic test_rule_limits();
		setup_map(4, 4, 1, 9, 9, 0, 16'h8000);
		send_cell(pick_sample(), 1'b1);
		run_cells(32);
		drain_cells();
		write_reg(REG_DEATH_LIMIT, 16'd0);
		write_reg(REG_BIRTH_LIMIT, 16'd0);
		send_cell(pick_sample(), 1'b1);
		run_cells(32);
		drain_cells();
		write_reg(REG_DEATH_LIMIT, 16'd8);
		write_reg(REG_BIRTH_LIMIT, 16'd8);
		write_reg(REG_EDGE_WALLS, 16'd1);
		send_cell(pick_sample(), 1'b1);
		run_cells(32);
		drain_cells();
	endtask

	// Out-of-range sizes saturate; shrinking mid-fill ends the fill at once.
	task automatic test_size_saturation();
		setup_map(127, 0, 1, 4, 4, 1, 16'h7333);  // 64 wide, 4 deep
		send_cell(pick_sample(), 1'b1);
		run_cells(69);                            // past column 63 into row 1
		drain_cells();
		write_reg(REG_GRID_WIDTH, 16'd5);
		run_cells(22);                            // empty closing item, one pass, done
		drain_cells();
		write_reg(REG_GRID_WIDTH, 16'd0);         // 4 wide
		write_reg(REG_GRID_DEPTH, 16'd127);       // 64 deep
		send_cell(pick_sample(), 1'b1);
		run_cells(19);                            // into row 4
		drain_cells();
		write_reg(REG_GRID_DEPTH, 16'd4);
		run_cells(18);                            // empty closing item, one pass, done
		drain_cells();
	endtask

	// Restart mid-fill, mid-pass and after completion.
	task automatic test_restarts();
		setup_map(4, 4, 1, 4, 4, 1, 16'h7333);
		send_cell(pick_sample(), 1'b1);
		run_cells(7);
		send_cell(pick_sample(), 1'b1);
		run_cells(19);
		send_cell(pick_sample(), 1'b1);
		run_cells(32);
		send_cell(pick_sample(), 1'b1);
		run_cells(2);
		drain_cells();
	endtask

	// Pass count cut to the passes already done ends the map at the end of the current pass.
	task automatic test_pass_count_lowered();
		setup_map(4, 4, 255, 3, 5, 0, 16'h6000);
		send_cell(pick_sample(), 1'b1);
		run_cells(36);
		drain_cells();
		write_reg(REG_PASS_COUNT, 16'd1);
		run_cells(13);
		drain_cells();
	endtask

	// Random maps within 6x6, with stray restarts and register changes between items.
	task automatic test_random_maps(input int budget);
		int                   stop_at;
		int                   dice;
		logic [CFG_IDX_W-1:0] sel;
		stop_at = cells_sent + budget;
		while (cells_sent < stop_at) begin
			bursts_on = ($urandom_range(0, 3) != 0);
			for (sel = REG_GRID_WIDTH; sel <= REG_WALL_CHANCE; sel++)
				write_reg(sel, random_reg_value(sel));
			send_cell(pick_sample(), 1'b1);
			while (gen_phase != PH_DONE && cells_sent < stop_at) begin
				dice = $urandom_range(0, 99);
				if (dice < 3) begin
					send_cell(pick_sample(), 1'b1);
				end else if (dice < 7) begin
					drain_cells();
					sel = CFG_IDX_W'($urandom_range(REG_GRID_WIDTH, REG_WALL_CHANCE));
					write_reg(sel, random_reg_value(sel));
				end else begin
					send_cell(pick_sample(), 1'b0);
				end
			end
			repeat ($urandom_range(1, 2)) send_cell(pick_sample(), $urandom_range(0, 9) == 0);
			drain_cells();
		end
		bursts_on = 1'b1;
	endtask

	// Closing map at full rate, no idling on either side.
	task automatic test_quiet_tail();
		bursts_on = 1'b0;
		setup_map(4, 4, 1, 4, 4, 1, 16'h7333);
		send_cell(pick_sample(), 1'b1);
		run_cells(32);
		drain_cells();
	endtask

	// ---------------------------------------------------------------
	// Result side: random back-pressure and the scoreboard
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (stall_left > 0) begin
			cell_out.ready <= 1'b0;
			stall_left     <= stall_left - 1;
		end else if (bursts_on && $urandom_range(0, 99) < 20) begin
			cell_out.ready <= 1'b0;
			stall_left     <= $urandom_range(0, 3);
		end else begin
			cell_out.ready <= 1'b1;
		end
	end

	function automatic void check_field(input string name, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatch_count++;
		end
	endfunction

	always @(posedge clk) begin : check_cells
		out_item_t want;
		out_item_t got;
		if (arst_n && cell_out.valid === 1'b1 && cell_out.ready === 1'b1) begin
			got = cell_out.data;
			if (cells_due.size() == 0) begin
				$error("result item with no item pending: x %0d y %0d", got.cell_x, got.cell_y);
				mismatch_count++;
			end else begin
				want = cells_due.pop_front();
				check_field("cell_x", 8'(want.cell_x), 8'(got.cell_x));
				check_field("cell_y", 8'(want.cell_y), 8'(got.cell_y));
				check_field("is_wall", 8'(want.is_wall), 8'(got.is_wall));
				check_field("wrote", 8'(want.wrote), 8'(got.wrote));
				check_field("phase_now", 8'(want.phase_now), 8'(got.phase_now));
				check_field("pass_index", want.pass_index, got.pass_index);
				check_field("finished", 8'(want.finished), 8'(got.finished));
				results_checked++;
			end
		end
	end

	// Watchdog: cycles in a row with no item moving on either channel.
	always @(posedge clk) begin
		if ((cell_in.valid === 1'b1 && cell_in.ready === 1'b1) ||
				(cell_out.valid === 1'b1 && cell_out.ready === 1'b1))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$error("no item moved for %0d cycles, %0d results outstanding",
				WATCHDOG_LIMIT, cells_due.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Sequence
	// ---------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		cfg_we         = 1'b0;
		cfg_index      = '0;
		cfg_data       = '0;
		cell_in.valid  = 1'b0;
		cell_in.data   = '0;
		bursts_on      = 1'b1;

		map_cfg.grid_width  = RST_GRID_WIDTH;
		map_cfg.grid_depth  = RST_GRID_DEPTH;
		map_cfg.pass_count  = RST_PASS_COUNT;
		map_cfg.death_limit = RST_DEATH_LIMIT;
		map_cfg.birth_limit = RST_BIRTH_LIMIT;
		map_cfg.edge_walls  = RST_EDGE_WALLS;
		map_cfg.wall_chance = RST_WALL_CHANCE;
		map_sel     = 1'b0;
		scan_pos    = 0;
		passes_seen = '0;
		gen_phase   = PH_FILL;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_prime_map();
		test_fill_extremes();
		test_rule_limits();
		test_size_saturation();
		test_restarts();
		test_pass_count_lowered();
		test_random_maps(30);
		test_quiet_tail();

		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d cell items and %0d checked results over %0d finished maps",
			cells_sent, results_checked, maps_done);
		$display("with %0d register writes, %0d mismatches", reg_writes, mismatch_count);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

// File: filelist.f
rtl/cag_pkg.sv
rtl/cag_in_if.sv
rtl/cag_out_if.sv
rtl/cag_ram.sv
rtl/cag_ctrl.sv
rtl/cag_dpath.sv
rtl/cave_automaton_generator.sv
bench/tb_cave_automaton_generator.sv
